[hdl/awm_pkg.sv]
// shared constants and types for the arcade drive wheel mixer
`timescale 1ns / 1ps

package awm_pkg;

  localparam int FRAC_IN   = 10;
  localparam int FRAC_OUT  = 14;
  localparam int UNIT_IN   = 1 << FRAC_IN;
  localparam int FULL_OUT  = 1 << FRAC_OUT;
  localparam int CFG_W     = 15;
  localparam int OUT_W     = 16;
  // quotient bits of 2*num/den below the overflow bit
  localparam int Q_BITS    = 16;
  // numerator is |v| * 2^25, the extra bit feeds the round-half-up trick
  localparam int NUM_SHIFT = FRAC_IN + FRAC_OUT + 1;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(UNIT_IN);
  // doubled quotient at or above this rounds to full scale
  localparam logic [Q_BITS-1:0] SAT_X = Q_BITS'(2 * FULL_OUT - 1);

  typedef struct packed {
    logic neg_l;
    logic neg_r;
    logic zero_l;
    logic zero_r;
  } side_t;

endpackage

[hdl/awm_mix.sv]
// quadrant mixing of forward speed and turn rate into wheel magnitudes
`timescale 1ns / 1ps

module awm_mix #(
  parameter int SW = 16,
  parameter int OW = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [SW-1:0] f_i,
  input  logic signed [SW-1:0] t_i,
  output logic [SW-1:0]        mag_l_o,
  output logic [SW-1:0]        mag_r_o,
  output awm_pkg::side_t       side_o,
  output logic [OW-1:0]        op_o
);
  import awm_pkg::*;

  logic [SW-1:0] f_u, t_u, abs_f, abs_t, big, o_mag;
  logic [SW:0]   sum, o_abs;
  logic          f_neg, t_neg, same, o_neg, norm;
  logic [SW-1:0] mag_l_d, mag_r_d;
  logic [OW-1:0] op_d;
  side_t         side_d;

  always_comb begin
    f_u   = f_i;
    t_u   = t_i;
    f_neg = f_u[SW-1];
    t_neg = t_u[SW-1];
    abs_f = f_neg ? (~f_u + SW'(1)) : f_u;
    abs_t = t_neg ? (~t_u + SW'(1)) : t_u;
    big   = (abs_f > abs_t) ? abs_f : abs_t;
    same  = (f_neg == t_neg);
    // the wheel that is not the lead gets the difference or the sum
    if (same) begin
      sum = {f_u[SW-1], f_u} - {t_u[SW-1], t_u};
    end else begin
      sum = {f_u[SW-1], f_u} + {t_u[SW-1], t_u};
    end
    o_neg = sum[SW];
    o_abs = o_neg ? (~sum + (SW+1)'(1)) : sum;
    o_mag = o_abs[SW-1:0];
    // the lead wheel always holds the larger magnitude
    norm  = OW'(big) > OW'(UNIT_IN);
    op_d  = norm ? OW'(big) : OW'(UNIT_IN);
    mag_l_d       = same ? big : o_mag;
    mag_r_d       = same ? o_mag : big;
    side_d.neg_l  = same ? f_neg : o_neg;
    side_d.neg_r  = same ? o_neg : f_neg;
    side_d.zero_l = (mag_l_d == '0);
    side_d.zero_r = (mag_r_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_l_o <= mag_l_d;
      mag_r_o <= mag_r_d;
      side_o  <= side_d;
      op_o    <= op_d;
    end
  end

endmodule

[hdl/awm_scale.sv]
// forms the shared divisor and the two numerators
`timescale 1ns / 1ps

module awm_scale #(
  parameter int SW = 16,
  parameter int OW = 16,
  parameter int DW = 31,
  parameter int RW = 47
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [SW-1:0]              mag_l_i,
  input  logic [SW-1:0]              mag_r_i,
  input  awm_pkg::side_t             side_i,
  input  logic [OW-1:0]              op_i,
  input  logic [awm_pkg::CFG_W-1:0]  cfg_i,
  output logic [RW-1:0]              rem_l_o,
  output logic [RW-1:0]              rem_r_o,
  output logic [DW-1:0]              den_o,
  output awm_pkg::side_t             side_o
);
  import awm_pkg::*;

  logic [DW-1:0] den_d;
  logic [RW-1:0] rem_l_d, rem_r_d;

  always_comb begin
    // without normalization the divisor is 1024*S, so one numerator form serves both
    den_d   = DW'(op_i) * DW'(cfg_i);
    rem_l_d = RW'(mag_l_i) << NUM_SHIFT;
    rem_r_d = RW'(mag_r_i) << NUM_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o   <= den_d;
      rem_l_o <= rem_l_d;
      rem_r_o <= rem_r_d;
      side_o  <= side_i;
    end
  end

endmodule

[hdl/awm_div_cell.sv]
// one restoring divider cell, resolves one quotient bit for both wheels
`timescale 1ns / 1ps

module awm_div_cell #(
  parameter int RW    = 47,
  parameter int DW    = 31,
  parameter int QW    = 17,
  parameter int SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [RW-1:0]  rem_l_i,
  input  logic [RW-1:0]  rem_r_i,
  input  logic [DW-1:0]  den_i,
  input  logic [QW-1:0]  q_l_i,
  input  logic [QW-1:0]  q_r_i,
  input  awm_pkg::side_t side_i,
  output logic [RW-1:0]  rem_l_o,
  output logic [RW-1:0]  rem_r_o,
  output logic [DW-1:0]  den_o,
  output logic [QW-1:0]  q_l_o,
  output logic [QW-1:0]  q_r_o,
  output awm_pkg::side_t side_o
);
  import awm_pkg::*;

  logic [RW-1:0] d_sh, rem_l_d, rem_r_d;
  logic [RW:0]   diff_l, diff_r;
  logic          ge_l, ge_r;
  logic [QW-1:0] q_l_d, q_r_d;

  always_comb begin
    d_sh    = RW'(den_i) << SHIFT;
    diff_l  = {1'b0, rem_l_i} - {1'b0, d_sh};
    diff_r  = {1'b0, rem_r_i} - {1'b0, d_sh};
    ge_l    = ~diff_l[RW];
    ge_r    = ~diff_r[RW];
    rem_l_d = ge_l ? diff_l[RW-1:0] : rem_l_i;
    rem_r_d = ge_r ? diff_r[RW-1:0] : rem_r_i;
    q_l_d        = q_l_i;
    q_r_d        = q_r_i;
    q_l_d[SHIFT] = ge_l;
    q_r_d[SHIFT] = ge_r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_l_o <= rem_l_d;
      rem_r_o <= rem_r_d;
      den_o   <= den_i;
      q_l_o   <= q_l_d;
      q_r_o   <= q_r_d;
      side_o  <= side_i;
    end
  end

endmodule

[hdl/awm_round.sv]
// rounds, saturates and signs the two wheel quotients
`timescale 1ns / 1ps

module awm_round (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [awm_pkg::Q_BITS:0]          q_l_i,
  input  logic [awm_pkg::Q_BITS:0]          q_r_i,
  input  awm_pkg::side_t                    side_i,
  output logic signed [awm_pkg::OUT_W-1:0]  left_o,
  output logic signed [awm_pkg::OUT_W-1:0]  right_o
);
  import awm_pkg::*;

  // q holds floor(2*num/den) with an overflow bit on top
  function automatic logic [OUT_W-1:0] drive(input logic [Q_BITS:0] q,
                                             input logic neg, input logic zero);
    logic [Q_BITS-1:0] x;
    logic [Q_BITS:0]   inc;
    logic [OUT_W-1:0]  mag;
    x   = q[Q_BITS-1:0];
    inc = (Q_BITS+1)'(x) + (Q_BITS+1)'(1);
    if (zero) begin
      mag = '0;
    end else if (q[Q_BITS] || (x >= SAT_X)) begin
      mag = OUT_W'(FULL_OUT);
    end else begin
      mag = OUT_W'(inc[Q_BITS:1]);
    end
    return neg ? (~mag + OUT_W'(1)) : mag;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      left_o  <= drive(q_l_i, side_i.neg_l, side_i.zero_l);
      right_o <= drive(q_r_i, side_i.neg_r, side_i.zero_r);
    end
  end

endmodule

[hdl/arcade_drive_wheel_mixer.sv]
// each transfer in passes the mix, scale, divider cell and round registers in order
// one speed command per cycle unless stalled: mix, multiply, 17 divider cells, round
// the 17 chained divider cells set the depth, one quotient bit per cell
// stalls collapse bubbles stage by stage, so input stays open until every stage is full
// reset clears all stage valid bits and sets max_speed_q to 1024
`timescale 1ns / 1ps

module arcade_drive_wheel_mixer #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [awm_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SPEED_WIDTH-1:0]     forward_speed_i,
  input  logic signed [SPEED_WIDTH-1:0]     turn_rate_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [awm_pkg::OUT_W-1:0]  left_drive_o,
  output logic signed [awm_pkg::OUT_W-1:0]  right_drive_o
);
  import awm_pkg::*;

  localparam int OW = (SPEED_WIDTH > FRAC_IN + 1) ? SPEED_WIDTH : FRAC_IN + 1;
  localparam int DW = OW + CFG_W;
  localparam int RW = DW + Q_BITS;
  localparam int NC = Q_BITS + 1;
  localparam int NS = NC + 3;

  logic [CFG_W-1:0] max_speed_q;
  logic [NS-1:0]    vld_q;
  logic [NS:0]      rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      max_speed_q <= cfg_wdata_i;
    end
  end

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  logic [SPEED_WIDTH-1:0] mag_l, mag_r;
  logic [OW-1:0]          op;
  side_t                  mix_side;

  awm_mix #(.SW(SPEED_WIDTH), .OW(OW)) u_mix (
    .clk_i   (clk_i),
    .en_i    (rdy[0]),
    .f_i     (forward_speed_i),
    .t_i     (turn_rate_i),
    .mag_l_o (mag_l),
    .mag_r_o (mag_r),
    .side_o  (mix_side),
    .op_o    (op)
  );

  logic [RW-1:0] rem_l [NC+1];
  logic [RW-1:0] rem_r [NC+1];
  logic [DW-1:0] den   [NC+1];
  logic [NC-1:0] q_l   [NC+1];
  logic [NC-1:0] q_r   [NC+1];
  side_t         side  [NC+1];

  awm_scale #(.SW(SPEED_WIDTH), .OW(OW), .DW(DW), .RW(RW)) u_scale (
    .clk_i   (clk_i),
    .en_i    (rdy[1]),
    .mag_l_i (mag_l),
    .mag_r_i (mag_r),
    .side_i  (mix_side),
    .op_i    (op),
    .cfg_i   (max_speed_q),
    .rem_l_o (rem_l[0]),
    .rem_r_o (rem_r[0]),
    .den_o   (den[0]),
    .side_o  (side[0])
  );

  assign q_l[0] = '0;
  assign q_r[0] = '0;

  // first cell checks for overflow, then quotient bits from the top down
  for (genvar c = 0; c < NC; c++) begin : g_cell
    awm_div_cell #(.RW(RW), .DW(DW), .QW(NC), .SHIFT(NC - 1 - c)) u_cell (
      .clk_i   (clk_i),
      .en_i    (rdy[c+2]),
      .rem_l_i (rem_l[c]),
      .rem_r_i (rem_r[c]),
      .den_i   (den[c]),
      .q_l_i   (q_l[c]),
      .q_r_i   (q_r[c]),
      .side_i  (side[c]),
      .rem_l_o (rem_l[c+1]),
      .rem_r_o (rem_r[c+1]),
      .den_o   (den[c+1]),
      .q_l_o   (q_l[c+1]),
      .q_r_o   (q_r[c+1]),
      .side_o  (side[c+1])
    );
  end

  awm_round u_round (
    .clk_i   (clk_i),
    .en_i    (rdy[NS-1]),
    .q_l_i   (q_l[NC]),
    .q_r_i   (q_r[NC]),
    .side_i  (side[NC]),
    .left_o  (left_drive_o),
    .right_o (right_drive_o)
  );

endmodule
